/* rtl/core/lius_pkg.sv */
package lius_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int MAX_FACTOR  = 64;
  localparam int FACTOR_BITS = 7;
  localparam int DIFF_BITS   = SAMPLE_BITS + 1;
  localparam int DCNT_BITS   = $clog2(SAMPLE_BITS + 1);
  localparam int IDX_BITS    = $clog2(MAX_FACTOR);
  localparam logic [FACTOR_BITS-1:0] FACTOR_RESET = FACTOR_BITS'(4);

  // Sequencer steps.
  localparam int STEP_BITS = 2;
  localparam logic [STEP_BITS-1:0] STEP_WAIT = 2'd0;
  localparam logic [STEP_BITS-1:0] STEP_DIV  = 2'd1;
  localparam logic [STEP_BITS-1:0] STEP_FIX  = 2'd2;
  localparam logic [STEP_BITS-1:0] STEP_EMIT = 2'd3;

  // Jump conditions: jump to the target when true, otherwise hold the step.
  localparam logic [1:0] COND_ALWAYS = 2'd0;
  localparam logic [1:0] COND_PAIR   = 2'd1;
  localparam logic [1:0] COND_DIVEND = 2'd2;
  localparam logic [1:0] COND_LAST   = 2'd3;

  typedef struct packed {
    logic                 in_ready;
    logic                 div_en;
    logic                 fix_en;
    logic                 emit_en;
    logic [1:0]           cond;
    logic [STEP_BITS-1:0] target;
  } ctrl_word_t;

  typedef struct packed {
    logic pair_accept;
    logic div_done;
    logic emit_last;
    logic have_prev;
  } dp_status_t;

  function automatic ctrl_word_t microcode(input logic [STEP_BITS-1:0] step);
    ctrl_word_t w;
    w = '0;
    case (step)
      STEP_WAIT: begin
        w.in_ready = 1'b1;
        w.cond     = COND_PAIR;
        w.target   = STEP_DIV;
      end
      STEP_DIV: begin
        w.div_en = 1'b1;
        w.cond   = COND_DIVEND;
        w.target = STEP_FIX;
      end
      STEP_FIX: begin
        w.fix_en = 1'b1;
        w.cond   = COND_ALWAYS;
        w.target = STEP_EMIT;
      end
      STEP_EMIT: begin
        w.emit_en = 1'b1;
        w.cond    = COND_LAST;
        w.target  = STEP_WAIT;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

/* rtl/core/lius_seq.sv */
module lius_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  lius_pkg::dp_status_t status,
  output lius_pkg::ctrl_word_t ctrl
);

  logic [lius_pkg::STEP_BITS-1:0] step_r;
  logic [lius_pkg::STEP_BITS-1:0] step_nxt;
  logic                           cond_true;

  assign ctrl = lius_pkg::microcode(step_r);

  always_comb begin
    case (ctrl.cond)
      lius_pkg::COND_ALWAYS: cond_true = 1'b1;
      lius_pkg::COND_PAIR:   cond_true = status.pair_accept;
      lius_pkg::COND_DIVEND: cond_true = status.div_done;
      lius_pkg::COND_LAST:   cond_true = status.emit_last;
      default:               cond_true = 1'b1;
    endcase
    step_nxt = cond_true ? ctrl.target : step_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= lius_pkg::STEP_WAIT;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

/* rtl/core/lius_div.sv */
module lius_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic                                step_en,
  input  logic [lius_pkg::SAMPLE_BITS-1:0]    dividend,
  input  logic [lius_pkg::FACTOR_BITS-1:0]    divisor,
  output logic [lius_pkg::SAMPLE_BITS-1:0]    quotient,
  output logic [lius_pkg::FACTOR_BITS-1:0]    remainder,
  output logic                                done
);

  logic [lius_pkg::SAMPLE_BITS-1:0] quo_r, quo_nxt;
  logic [lius_pkg::FACTOR_BITS-1:0] rem_r, rem_nxt;
  logic [lius_pkg::DCNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic [lius_pkg::FACTOR_BITS:0]   trial;
  logic                             fits;

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign done      = (cnt_r == '0);

  always_comb begin
    trial   = {rem_r, quo_r[lius_pkg::SAMPLE_BITS-1]};
    fits    = (trial >= {1'b0, divisor});
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = lius_pkg::DCNT_BITS'(lius_pkg::SAMPLE_BITS);
    end else if (step_en && !done) begin
      quo_nxt = {quo_r[lius_pkg::SAMPLE_BITS-2:0], fits};
      rem_nxt = fits ? lius_pkg::FACTOR_BITS'(trial - {1'b0, divisor})
                     : lius_pkg::FACTOR_BITS'(trial);
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

endmodule

/* rtl/core/lius_dp.sv */
module lius_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  lius_pkg::ctrl_word_t                   ctrl,
  input  logic [lius_pkg::FACTOR_BITS-1:0]       factor,
  input  logic                                   in_tvalid,
  input  logic signed [lius_pkg::SAMPLE_BITS-1:0] in_sample,
  input  logic                                   in_row_start,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic signed [lius_pkg::SAMPLE_BITS-1:0] out_value,
  output logic                                   out_last,
  output lius_pkg::dp_status_t                   status
);

  localparam int SB = lius_pkg::SAMPLE_BITS;
  localparam int DB = lius_pkg::DIFF_BITS;
  localparam int FB = lius_pkg::FACTOR_BITS;
  localparam int IB = lius_pkg::IDX_BITS;

  logic signed [SB-1:0] prev_r, a_r;
  logic                 have_prev_r;
  logic                 neg_r;
  logic signed [DB-1:0] diff;
  logic [SB-1:0]        diff_mag;
  logic                 accept, pair;
  logic [SB-1:0]        uq;
  logic [FB-1:0]        urem;
  logic                 div_done;
  logic signed [DB-1:0] dq_r, acc_q_r;
  logic [FB-1:0]        dr_r, acc_r_r;
  logic [IB-1:0]        idx_r;
  logic                 emit, is_last;
  logic [FB:0]          r_sum;
  logic                 carry;
  logic                 out_valid_r;
  logic signed [SB-1:0] out_value_r;
  logic                 out_last_r;

  assign accept   = ctrl.in_ready && in_tvalid;
  assign pair     = accept && !in_row_start && have_prev_r;
  assign diff     = DB'(in_sample) - DB'(prev_r);
  assign diff_mag = diff[DB-1] ? SB'(-diff) : SB'(diff);

  lius_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (pair),
    .step_en   (ctrl.div_en),
    .dividend  (diff_mag),
    .divisor   (factor),
    .quotient  (uq),
    .remainder (urem),
    .done      (div_done)
  );

  assign emit    = ctrl.emit_en && (!out_valid_r || out_tready);
  assign is_last = ({1'b0, idx_r} == (factor - 1'b1));
  assign r_sum   = {1'b0, acc_r_r} + {1'b0, dr_r};
  assign carry   = (r_sum >= {1'b0, factor});

  assign status.pair_accept = pair;
  assign status.div_done    = div_done;
  assign status.emit_last   = emit && is_last;
  assign status.have_prev   = have_prev_r;

  assign out_tvalid = out_valid_r;
  assign out_value  = out_value_r;
  assign out_last   = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        have_prev_r <= 1'b1;
        prev_r      <= in_sample;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pair) begin
      a_r   <= prev_r;
      neg_r <= diff[DB-1];
    end
    if (ctrl.fix_en) begin
      if (!neg_r) begin
        dq_r <= DB'(uq);
        dr_r <= urem;
      end else if (urem == '0) begin
        dq_r <= -DB'(uq);
        dr_r <= '0;
      end else begin
        dq_r <= -(DB'(uq) + DB'(1));
        dr_r <= factor - urem;
      end
      acc_q_r <= '0;
      acc_r_r <= '0;
      idx_r   <= '0;
    end else if (emit) begin
      out_value_r <= a_r + acc_q_r[SB-1:0];
      out_last_r  <= is_last;
      acc_q_r     <= acc_q_r + dq_r + DB'(carry);
      acc_r_r     <= carry ? FB'(r_sum - {1'b0, factor}) : FB'(r_sum);
      idx_r       <= idx_r + 1'b1;
    end
  end

endmodule

/* rtl/core/linear_interp_upsampler_core.sv */
// Linear interpolation upsampler.
// Input samples arrive on in_tdata (sample) with in_tuser (row_start) and
// are accepted when in_tvalid and in_tready are both high. The first sample
// of a row is only stored. Every later sample b, with the previous sample a,
// produces F results a + floor((b - a) * n / F), n = 0 .. F-1, on out_tdata,
// with out_tlast set on the final result of the run.
// The factor F is written through cfg_we/cfg_wdata; the user must write it
// only while the block is idle, which the block itself does not enforce.
// Zero acts as one and values above 64 act as 64. A row-start transaction
// leaves the block waiting for the next input. A pair is accepted, then the
// difference is divided by F in a bit-serial divider (16 shift steps, then
// the divider is seen done), the sign is corrected, and the results go one
// per cycle into the output register while the receiver does not stall.
// When the receiver stalls, the output register holds its result and the
// sequencer waits; the next input is accepted while the last result of a run
// still waits in the output register.
// Reset sets the factor to 4, clears the stored sample and opens no row.
module linear_interp_upsampler_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [lius_pkg::SAMPLE_BITS-1:0]   in_tdata,  // [15:0] sample
  input  logic                               in_tuser,  // [0] row_start
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [lius_pkg::SAMPLE_BITS-1:0]   out_tdata, // [15:0] value
  output logic                               out_tlast,
  input  logic                               cfg_we,
  input  logic [lius_pkg::FACTOR_BITS-1:0]   cfg_wdata
);

  logic [lius_pkg::FACTOR_BITS-1:0] factor_r;
  logic [lius_pkg::FACTOR_BITS-1:0] factor_eff;
  lius_pkg::ctrl_word_t             ctrl;
  lius_pkg::dp_status_t             status;
  logic signed [lius_pkg::SAMPLE_BITS-1:0] out_value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factor_r <= lius_pkg::FACTOR_RESET;
    end else if (cfg_we) begin
      factor_r <= cfg_wdata;
    end
  end

  always_comb begin
    if (factor_r == '0) begin
      factor_eff = lius_pkg::FACTOR_BITS'(1);
    end else if (factor_r > lius_pkg::FACTOR_BITS'(lius_pkg::MAX_FACTOR)) begin
      factor_eff = lius_pkg::FACTOR_BITS'(lius_pkg::MAX_FACTOR);
    end else begin
      factor_eff = factor_r;
    end
  end

  lius_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl)
  );

  lius_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctrl         (ctrl),
    .factor       (factor_eff),
    .in_tvalid    (in_tvalid),
    .in_sample    (in_tdata),
    .in_row_start (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_value    (out_value),
    .out_last     (out_tlast),
    .status       (status)
  );

  assign in_tready = ctrl.in_ready;
  assign out_tdata = out_value;

`ifndef NO_ASSERTIONS
  // A pair transaction starts a run, so no input is taken on the next cycle.
  a_pair_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !in_tuser && status.have_prev) |=> !in_tready)
    else $error("input accepted right after a pair transaction");

  // While a run is unfinished the input side stays closed.
  a_run_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> !in_tready)
    else $error("input ready while a run is still in progress");

  // The run ends only through a marked result.
  a_run_end_marked: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(ctrl.emit_en) && in_tready) |-> (out_tvalid && out_tlast))
    else $error("sequencer state inconsistent at end of run");
`endif

endmodule

/* tb/linear_interp_upsampler_core_tb.sv */
module linear_interp_upsampler_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES  = 1_000_000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 100;
  localparam int RANDOM_ITEMS  = 340;

  typedef struct {
    logic [lius_pkg::SAMPLE_BITS-1:0] value;
    logic                             tail;
  } interp_point_t;

  class upsample_scoreboard;
    logic [lius_pkg::FACTOR_BITS-1:0] factor_reg;
    logic [lius_pkg::SAMPLE_BITS-1:0] held_sample;
    bit                               row_open;
    interp_point_t                    pending_points[$];
    int                               errors;
    int                               pairs;
    int                               compared;

    function new();
      factor_reg  = lius_pkg::FACTOR_RESET;
      held_sample = '0;
      row_open    = 1'b0;
      errors      = 0;
      pairs       = 0;
      compared    = 0;
    endfunction

    function void set_factor(input logic [lius_pkg::FACTOR_BITS-1:0] v);
      factor_reg = v;
    endfunction

    function int run_length();
      if (factor_reg == '0) begin
        return 1;
      end
      if (factor_reg > lius_pkg::MAX_FACTOR) begin
        return lius_pkg::MAX_FACTOR;
      end
      return int'(factor_reg);
    endfunction

    // A sample either opens a row or closes a pair, which yields a run of
    // points stepping from the held sample toward the new one with floor rounding.
    function void note_sample(input logic [lius_pkg::SAMPLE_BITS-1:0] raw,
                              input logic start);
      int a, b, diff, num, q, f;
      interp_point_t p;
      if (start || !row_open) begin
        held_sample = raw;
        row_open    = 1'b1;
        return;
      end
      a    = $signed(held_sample);
      b    = $signed(raw);
      diff = b - a;
      f    = run_length();
      for (int n = 0; n < f; n++) begin
        num     = diff * n;
        q       = (num >= 0) ? num / f : -((-num + f - 1) / f);
        p.value = lius_pkg::SAMPLE_BITS'(a + q);
        p.tail  = (n == f - 1);
        pending_points.insert(pending_points.size(), p);
      end
      held_sample = raw;
      pairs++;
    endfunction

    function void check_point(input logic [lius_pkg::SAMPLE_BITS-1:0] value,
                              input logic tail);
      interp_point_t p;
      if (pending_points.size() == 0) begin
        $error("unexpected result: value %0d, last_of_run %0b", $signed(value), tail);
        errors++;
        return;
      end
      p = pending_points.pop_front();
      compared++;
      if (value !== p.value) begin
        $error("value mismatch: expected %0d, actual %0d", $signed(p.value), $signed(value));
        errors++;
      end
      if (tail !== p.tail) begin
        $error("last_of_run mismatch: expected %0b, actual %0b", p.tail, tail);
        errors++;
      end
    endfunction

    function int pending();
      return pending_points.size();
    endfunction
  endclass

  logic                             clk;
  logic                             rst_n;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [lius_pkg::SAMPLE_BITS-1:0] in_tdata;
  logic                             in_tuser;
  logic                             out_tvalid;
  logic                             out_tready;
  logic [lius_pkg::SAMPLE_BITS-1:0] out_tdata;
  logic                             out_tlast;
  logic                             cfg_we;
  logic [lius_pkg::FACTOR_BITS-1:0] cfg_wdata;

  upsample_scoreboard sb = new();

  bit quiet = 1'b0;
  int hold_requests = 0;
  int holds_served = 0;
  int cycle_count = 0;
  int samples_sent = 0;
  int factor_writes = 0;

  linear_interp_upsampler_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      sb.note_sample(in_tdata, in_tuser);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_point(out_tdata, out_tlast);
    end
  end

  initial begin : receiver
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!quiet && $urandom_range(99) < 28) begin
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  task automatic send_sample(input logic [lius_pkg::SAMPLE_BITS-1:0] s, input logic start);
    while (!quiet && $urandom_range(99) < 28) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    in_tuser  <= start;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    samples_sent++;
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_factor(input logic [lius_pkg::FACTOR_BITS-1:0] v);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    sb.set_factor(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    factor_writes++;
  endtask

  function automatic logic [lius_pkg::FACTOR_BITS-1:0] pick_factor();
    case ($urandom_range(9))
      0: return '0;
      1: return lius_pkg::FACTOR_BITS'($urandom_range(lius_pkg::MAX_FACTOR + 1, 127));
      2: return lius_pkg::FACTOR_BITS'(lius_pkg::MAX_FACTOR);
      3, 4: return lius_pkg::FACTOR_BITS'($urandom_range(9, lius_pkg::MAX_FACTOR - 1));
      default: return lius_pkg::FACTOR_BITS'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic logic [lius_pkg::SAMPLE_BITS-1:0] next_sample(
    input logic [lius_pkg::SAMPLE_BITS-1:0] prev);
    case ($urandom_range(4))
      0, 1: return lius_pkg::SAMPLE_BITS'($urandom);
      2: return prev + lius_pkg::SAMPLE_BITS'($urandom_range(0, 40))
                - lius_pkg::SAMPLE_BITS'(20);
      3: return $urandom_range(1) ? 16'h7fff : 16'h8000;
      default: return $urandom_range(1) ? 16'hffff : 16'h0000;
    endcase
  endfunction

  initial begin : stimulus
    logic [lius_pkg::SAMPLE_BITS-1:0] walk;
    int random_sent;
    int phase;
    int burst;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = 1'b0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    walk       = '0;
    random_sent = 0;
    phase      = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // At the reset factor, a sample with no open row starts one.
    send_sample(16'h1234, 1'b0);
    send_sample(16'h7fff, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7fff, 1'b0);
    send_sample(16'hfffb, 1'b1);
    send_sample(16'hfff9, 1'b0);
    send_sample(16'hfff9, 1'b0);
    send_sample(16'h0003, 1'b0);
    send_sample(16'hffff, 1'b1);
    send_sample(16'h0000, 1'b0);
    settle();

    // A zero factor acts as one.
    write_factor('0);
    send_sample(16'h0064, 1'b0);
    send_sample(16'hff9c, 1'b0);
    settle();

    // Factors above the maximum saturate; then the maximum and a factor of one are run.
    write_factor(7'h7f);
    send_sample(16'h8000, 1'b1);
    send_sample(16'h7fff, 1'b0);
    settle();
    write_factor(lius_pkg::FACTOR_BITS'(lius_pkg::MAX_FACTOR + 1));
    send_sample(16'h8001, 1'b0);
    settle();
    write_factor(lius_pkg::FACTOR_BITS'(lius_pkg::MAX_FACTOR));
    send_sample(16'h0005, 1'b0);
    settle();
    write_factor(7'd1);
    send_sample(16'h4000, 1'b0);
    send_sample(16'hc000, 1'b0);
    send_sample(16'h5555, 1'b1);

    while (random_sent < RANDOM_ITEMS) begin
      settle();
      if (phase == 4) begin
        write_factor(7'd2);
      end else begin
        write_factor(pick_factor());
      end
      quiet = (phase == 2);
      if (phase == 4) begin
        hold_requests++;
      end
      burst = $urandom_range(20, 40);
      repeat (burst) begin
        walk = next_sample(walk);
        send_sample(walk, $urandom_range(99) < 8);
        random_sent++;
      end
      phase++;
    end
    quiet = 1'b0;
    settle();

    $display("Sent %0d samples forming %0d pairs across %0d factor writes.",
             samples_sent, sb.pairs, factor_writes);
    $display("Compared %0d interpolated results, including saturated and zero factors.",
             sb.compared);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
